>>> hdl/ccpp_pkg.sv
// Package with the beat types, status codes and CRC update function of the packet parser.
`timescale 1ns / 1ps

package ccpp_pkg;

    localparam int unsigned HDR_BYTES     = 9;
    localparam int unsigned TRAILER_BYTES = 2;
    localparam int unsigned COUNT_W       = 17;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [15:0]        CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY    = 16'h1021;
    localparam logic [15:0]        VERSION_RST = 16'd1;
    localparam logic [15:0]        MAX_PAY_RST = 16'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD      = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_SIZE_ERR    = 2'd1;
    localparam logic [1:0] STATUS_VERSION_ERR = 2'd2;
    localparam logic [1:0] STATUS_CRC_ERR     = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  version;
        logic [15:0] sequence_res;
        logic [7:0]  flag_bits;
        logic [7:0]  command;
        logic [7:0]  fragment_index;
        logic [7:0]  fragment_total;
        logic [15:0] payload_len;
        logic [15:0] crc_trailer;
        logic [15:0] crc_calc;
    } result_t;

    // CRC-16-CCITT, most significant bit first, one byte per call.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/crc_checked_packet_parser_top.sv
// A result beat is registered in out_reg from the beat held in the input register s1_item_reg.
// Throughput: one input beat per cycle while item_stall is low; the only loop is the one-byte CRC update.
// Each beat gives at most one result beat; bytes outside the payload give none
// unless they are the final byte, which gives the report.
// Reset clears all datagram state, sets expected_version to 1 and max_payload to 1024.
// Top level of the CRC-checked packet parser.
`timescale 1ns / 1ps

module crc_checked_packet_parser_top
    import ccpp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                  s1_valid_reg;
    item_t                 s1_item_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [7:0]            exp_version_reg;
    logic [15:0]           max_payload_reg;

    logic [COUNT_W-1:0]    count_reg,   count_next;
    logic [15:0]           crc_reg,     crc_next;
    logic [15:0]           trailer_reg, trailer_next;
    logic [15:0]           len_reg,     len_next;
    logic [6:0][7:0]       hdr_reg,     hdr_next;

    logic                  advance;
    logic                  fire;
    logic                  is_payload;
    logic                  emit;
    logic [COUNT_W-1:0]    pay_end;
    logic [COUNT_W-1:0]    need_len;
    logic [1:0]            status;
    result_t               result_next;

    assign advance    = !out_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && advance;
    assign item_stall = s1_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        len_next     = len_reg;
        hdr_next     = hdr_reg;
        is_payload   = 1'b0;
        pay_end      = COUNT_W'(HDR_BYTES) + {1'b0, len_reg};

        if (count_reg < COUNT_W'(HDR_BYTES))
        begin
            if (count_reg < COUNT_W'(7))
            begin
                hdr_next[count_reg[2:0]] = s1_item_reg.data_byte;
            end
            else if (count_reg == COUNT_W'(7))
            begin
                len_next[7:0] = s1_item_reg.data_byte;
            end
            else
            begin
                len_next[15:8] = s1_item_reg.data_byte;
            end
            crc_next = crc_update(crc_reg, s1_item_reg.data_byte);
        end
        else if (count_reg < pay_end)
        begin
            crc_next   = crc_update(crc_reg, s1_item_reg.data_byte);
            is_payload = 1'b1;
        end
        else if (count_reg == pay_end)
        begin
            trailer_next[7:0] = s1_item_reg.data_byte;
        end
        else if (count_reg == pay_end + COUNT_W'(1))
        begin
            trailer_next[15:8] = s1_item_reg.data_byte;
        end

        if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end

        need_len = COUNT_W'(HDR_BYTES + TRAILER_BYTES) + {1'b0, len_next};

        if (count_next < COUNT_W'(HDR_BYTES + TRAILER_BYTES))
        begin
            status = STATUS_SIZE_ERR;
        end
        else if (hdr_next[0] != exp_version_reg)
        begin
            status = STATUS_VERSION_ERR;
        end
        else if (len_next > max_payload_reg)
        begin
            status = STATUS_SIZE_ERR;
        end
        else if (count_next < need_len)
        begin
            status = STATUS_SIZE_ERR;
        end
        else if (trailer_next != crc_next)
        begin
            status = STATUS_CRC_ERR;
        end
        else
        begin
            status = STATUS_OK;
        end

        result_next = '0;
        emit        = s1_item_reg.last_byte || is_payload;
        if (s1_item_reg.last_byte)
        begin
            result_next.kind           = KIND_REPORT;
            result_next.status         = status;
            result_next.version        = hdr_next[0];
            result_next.sequence_res   = {hdr_next[2], hdr_next[1]};
            result_next.flag_bits      = hdr_next[3];
            result_next.command        = hdr_next[4];
            result_next.fragment_index = hdr_next[5];
            result_next.fragment_total = hdr_next[6];
            result_next.payload_len    = len_next;
            if (status == STATUS_OK || status == STATUS_CRC_ERR)
            begin
                result_next.crc_trailer = trailer_next;
                result_next.crc_calc    = crc_next;
            end
        end
        else
        begin
            result_next.kind         = KIND_PAYLOAD;
            result_next.payload_byte = s1_item_reg.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            trailer_reg <= '0;
            len_reg     <= '0;
            hdr_reg     <= '0;
        end
        else if (fire)
        begin
            if (s1_item_reg.last_byte)
            begin
                count_reg   <= '0;
                crc_reg     <= CRC_INIT;
                trailer_reg <= '0;
                len_reg     <= '0;
                hdr_reg     <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                crc_reg     <= crc_next;
                trailer_reg <= trailer_next;
                len_reg     <= len_next;
                hdr_reg     <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= VERSION_RST[7:0];
            max_payload_reg <= MAX_PAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_VERSION: exp_version_reg <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:      max_payload_reg <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> hdl/ccpp_checker.sv
// Port-level checker for the packet parser, bound to its top level.
`timescale 1ns / 1ps

module ccpp_checker
    import ccpp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input result_t                result
);

    // No result beat is offered in the cycle after reset has been seen.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result beat offered after reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // A forwarded payload beat carries OK status and zero version, length and CRC fields.
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_PAYLOAD |->
            result.status == STATUS_OK && result.version == 8'd0 &&
            result.payload_len == 16'd0 && result.crc_trailer == 16'd0 &&
            result.crc_calc == 16'd0)
        else $error("payload beat carries report fields");

    a_err_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_REPORT &&
        (result.status == STATUS_SIZE_ERR || result.status == STATUS_VERSION_ERR) |->
            result.crc_trailer == 16'd0 && result.crc_calc == 16'd0)
        else $error("CRC fields set on a size or version error");

    a_crc_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_REPORT &&
        (result.status == STATUS_OK || result.status == STATUS_CRC_ERR) |->
            ((result.crc_trailer == result.crc_calc) == (result.status == STATUS_OK)))
        else $error("CRC status disagrees with the CRC fields");

endmodule

bind crc_checked_packet_parser_top ccpp_checker u_ccpp_checker (.*);
